>>> sv/cst_pkg.sv
// shared types and constants for the connection slot table
// used by cst_ctrl, cst_dp and connection_slot_table_core
`default_nettype none

package cst_pkg;

    // slot count, a power of two: the home slot is the low bits of the flow id
    localparam int SLOTS      = 64;
    localparam int SLOT_AW    = $clog2(SLOTS);
    localparam int LIVE_W     = $clog2(SLOTS + 1);
    localparam int RESULT_CAP = 64;
    localparam int CAP_W      = $clog2(RESULT_CAP);

    localparam int FUNC_W   = 3;
    localparam int FLOW_W   = 32;
    localparam int HANDLE_W = 16;
    localparam int KIND_W   = 8;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int INFO_W   = HANDLE_W + KIND_W;

    // input tdata layout
    localparam int IN_FLOW_LSB   = 0;
    localparam int IN_HANDLE_LSB = IN_FLOW_LSB + FLOW_W;
    localparam int IN_KIND_LSB   = IN_HANDLE_LSB + HANDLE_W;
    localparam int IN_NOW_LSB    = IN_KIND_LSB + KIND_W;
    localparam int IN_DL_LSB     = IN_NOW_LSB + TIME_W;
    localparam int IN_DATA_W     = IN_DL_LSB + TIME_W;

    // output tdata layout
    localparam int OUT_USED_W = STATUS_W + FLOW_W + HANDLE_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 3'd0,
        FUNC_LOOKUP = 3'd1,
        FUNC_TOUCH  = 3'd2,
        FUNC_CLOSE  = 3'd3,
        FUNC_EXPIRE = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NOT_FOUND    = 2'd1,
        ST_FULL         = 2'd2,
        ST_NONE_EXPIRED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOME,
        S_PROBE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic cap;         // latch the input transaction
        logic rd_home;     // read the home slot of the incoming flow
        logic scan_start;  // read slot 0 and clear scan state
        logic home_exec;   // lookup, touch or close on the home slot
        logic probe_inc;   // move to the next probe candidate
        logic add_commit;  // store into the current candidate slot
        logic add_full;    // report table full
        logic scan_step;   // consume one scanned slot
        logic out_load;    // move the final result to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic probe_free;
        logic probe_end;
        logic scan_match;
        logic scan_end;
        logic pend_valid;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> sv/cst_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/cst_ctrl.sv
// control state machine of the connection slot table
// depends on cst_pkg; drives the datapath cst_dp through t_dp_cmd
`default_nettype none

module cst_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    input  wire logic [cst_pkg::FUNC_W-1:0] i_s_tuser,
    output logic                            o_s_tready,
    input  wire cst_pkg::t_dp_stat          i_stat,
    output cst_pkg::t_dp_cmd                o_cmd
);

    import cst_pkg::*;

    t_state r_state;
    t_state n_state;
    t_func  w_func;
    logic   w_scan_stall;

    assign w_func = t_func'(i_s_tuser);
    // a second match cannot replace the pending one while the output is busy
    assign w_scan_stall = i_stat.scan_match && i_stat.pend_valid && !i_stat.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (w_func) inside
                        FUNC_ADD:                           n_state = S_PROBE;
                        FUNC_LOOKUP, FUNC_TOUCH, FUNC_CLOSE: n_state = S_HOME;
                        FUNC_EXPIRE:                        n_state = S_SCAN;
                        default:                            n_state = S_IDLE;
                    endcase
                end
            end
            S_HOME: begin
                n_state = S_DONE;
            end
            S_PROBE: begin
                if (i_stat.probe_free || i_stat.probe_end) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (!w_scan_stall && i_stat.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    if (w_func == FUNC_EXPIRE) begin
                        o_cmd.scan_start = 1'b1;
                    end else begin
                        o_cmd.rd_home = 1'b1;
                    end
                end
            end
            S_HOME: begin
                o_cmd.home_exec = 1'b1;
            end
            S_PROBE: begin
                if (i_stat.probe_free) begin
                    o_cmd.add_commit = 1'b1;
                end else if (i_stat.probe_end) begin
                    o_cmd.add_full = 1'b1;
                end else begin
                    o_cmd.probe_inc = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = !w_scan_stall;
            end
            S_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && i_stat.probe_free) |=> r_state == S_DONE)
        else $error("add did not finish after finding a free slot");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd.cap)
        else $error("transaction captured outside idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.add_commit, o_cmd.add_full, o_cmd.probe_inc}))
        else $error("conflicting probe commands");

endmodule

`default_nettype wire

>>> sv/cst_dp.sv
// datapath of the connection slot table: slot rams, valid bits, live count,
// probe and scan counters, result and output registers; depends on cst_pkg, cst_ram
`default_nettype none

module cst_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [cst_pkg::FUNC_W-1:0]    i_s_tuser,
    input  wire logic [cst_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic      [cst_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                               o_m_tlast,
    input  wire cst_pkg::t_dp_cmd              i_cmd,
    output cst_pkg::t_dp_stat                  o_stat
);

    import cst_pkg::*;

    // latched transaction
    t_func               r_func;
    logic [FLOW_W-1:0]   r_flow;
    logic [HANDLE_W-1:0] r_handle;
    logic [KIND_W-1:0]   r_kind;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_deadline;

    logic [SLOTS-1:0]    r_valid;
    logic [LIVE_W-1:0]   r_live;
    logic [SLOT_AW-1:0]  r_k;
    logic [SLOT_AW-1:0]  r_idx;
    logic                r_pend;
    logic [FLOW_W-1:0]   r_pflow;
    logic [CAP_W-1:0]    r_nemit;

    t_status             r_res_status;
    logic [FLOW_W-1:0]   r_res_flow;
    logic [HANDLE_W-1:0] r_res_handle;

    logic                r_ovalid;
    t_status             r_o_status;
    logic [FLOW_W-1:0]   r_o_flow;
    logic [HANDLE_W-1:0] r_o_handle;
    logic [COUNT_W-1:0]  r_o_count;
    logic                r_o_last;

    logic [FLOW_W-1:0]   w_in_flow;
    logic [SLOT_AW-1:0]  w_home;
    logic [FLOW_W-1:0]   w_cand;
    logic [SLOT_AW-1:0]  w_cand_addr;
    logic                w_hit;
    logic                w_touch_hit;
    logic                w_close_hit;
    logic                w_match;
    logic [CAP_W:0]      w_n_after;
    logic                w_scan_end;
    logic                w_push_pend;
    logic                w_out_free;

    logic                ram_re;
    logic [SLOT_AW-1:0]  ram_raddr;
    logic [SLOT_AW-1:0]  ram_waddr;
    logic                flow_we;
    logic                info_we;
    logic [INFO_W-1:0]   info_wdata;
    logic                acc_we;
    logic [FLOW_W-1:0]   rd_flow;
    logic [INFO_W-1:0]   rd_info;
    logic [TIME_W-1:0]   rd_access;

    assign w_in_flow   = i_s_tdata[IN_FLOW_LSB +: FLOW_W];
    assign w_home      = r_flow[SLOT_AW-1:0];
    assign w_cand      = r_flow + FLOW_W'(r_k);
    assign w_cand_addr = w_cand[SLOT_AW-1:0];
    assign w_hit       = (r_flow != '0) && r_valid[w_home] && (rd_flow == r_flow);
    assign w_touch_hit = i_cmd.home_exec && w_hit && (r_func == FUNC_TOUCH);
    assign w_close_hit = i_cmd.home_exec && w_hit && (r_func == FUNC_CLOSE);

    // scan: rd data belongs to slot r_idx
    assign w_match     = r_valid[r_idx] && (rd_access < r_deadline);
    assign w_n_after   = {1'b0, r_nemit} + (CAP_W + 1)'(r_pend);
    assign w_scan_end  = (r_idx == SLOT_AW'(SLOTS - 1)) ||
                         (w_match && (w_n_after == (CAP_W + 1)'(RESULT_CAP - 1)));
    assign w_push_pend = i_cmd.scan_step && w_match && r_pend;
    assign w_out_free  = !r_ovalid || i_m_tready;

    always_comb begin
        o_stat.probe_free = (w_cand != '0) && !r_valid[w_cand_addr];
        o_stat.probe_end  = (r_k == SLOT_AW'(SLOTS - 1));
        o_stat.scan_match = w_match;
        o_stat.scan_end   = w_scan_end;
        o_stat.pend_valid = r_pend;
        o_stat.out_free   = w_out_free;
    end

    // ram ports
    assign ram_re    = i_cmd.rd_home || i_cmd.scan_start || (i_cmd.scan_step && !w_scan_end);
    assign ram_raddr = i_cmd.rd_home    ? w_in_flow[SLOT_AW-1:0] :
                       i_cmd.scan_start ? '0 : r_idx + SLOT_AW'(1);
    assign ram_waddr = i_cmd.add_commit ? w_cand_addr : w_home;
    assign flow_we   = i_cmd.add_commit;
    assign info_we   = i_cmd.add_commit || w_close_hit;
    // close keeps the handle and clears the kind
    assign info_wdata = i_cmd.add_commit ? {r_handle, r_kind}
                                         : {rd_info[INFO_W-1:KIND_W], KIND_W'(0)};
    assign acc_we    = i_cmd.add_commit || w_touch_hit;

    cst_ram #(.WIDTH(FLOW_W), .DEPTH(SLOTS)) u_flow_ram (
        .i_clk   (i_clk),
        .i_we    (flow_we),
        .i_waddr (ram_waddr),
        .i_wdata (w_cand),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_flow)
    );

    cst_ram #(.WIDTH(INFO_W), .DEPTH(SLOTS)) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (info_we),
        .i_waddr (ram_waddr),
        .i_wdata (info_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_info)
    );

    cst_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_access_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_now),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_access)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_live   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.add_commit) begin
                r_valid[w_cand_addr] <= 1'b1;
                r_live               <= r_live + LIVE_W'(1);
            end else if (w_close_hit) begin
                r_valid[w_home] <= 1'b0;
                r_live          <= r_live - LIVE_W'(1);
            end

            if (i_cmd.scan_start) begin
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step && w_match) begin
                r_pend <= 1'b1;
            end

            if (i_cmd.out_load || w_push_pend) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func     <= t_func'(i_s_tuser);
            r_flow     <= w_in_flow;
            r_handle   <= i_s_tdata[IN_HANDLE_LSB +: HANDLE_W];
            r_kind     <= i_s_tdata[IN_KIND_LSB +: KIND_W];
            r_now      <= i_s_tdata[IN_NOW_LSB +: TIME_W];
            r_deadline <= i_s_tdata[IN_DL_LSB +: TIME_W];
            r_k        <= '0;
            r_idx      <= '0;
            r_nemit    <= '0;
        end else begin
            if (i_cmd.probe_inc) begin
                r_k <= r_k + SLOT_AW'(1);
            end
            if (i_cmd.scan_step && !w_scan_end) begin
                r_idx <= r_idx + SLOT_AW'(1);
            end
            if (w_push_pend) begin
                r_nemit <= r_nemit + CAP_W'(1);
            end
        end

        if (i_cmd.scan_step && w_match) begin
            r_pflow <= rd_flow;
        end

        if (i_cmd.add_commit) begin
            r_res_status <= ST_OK;
            r_res_flow   <= w_cand;
            r_res_handle <= '0;
        end else if (i_cmd.add_full) begin
            r_res_status <= ST_FULL;
            r_res_flow   <= '0;
            r_res_handle <= '0;
        end else if (i_cmd.home_exec) begin
            r_res_status <= w_hit ? ST_OK : ST_NOT_FOUND;
            r_res_flow   <= '0;
            r_res_handle <= (w_hit && r_func == FUNC_LOOKUP) ? rd_info[INFO_W-1:KIND_W] : '0;
        end else if (i_cmd.scan_step && w_scan_end) begin
            r_res_status <= (w_match || r_pend) ? ST_OK : ST_NONE_EXPIRED;
            r_res_flow   <= w_match ? rd_flow : (r_pend ? r_pflow : '0);
            r_res_handle <= '0;
        end

        if (w_push_pend) begin
            r_o_status <= ST_OK;
            r_o_flow   <= r_pflow;
            r_o_handle <= '0;
            r_o_count  <= COUNT_W'(r_live);
            r_o_last   <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_flow   <= r_res_flow;
            r_o_handle <= r_res_handle;
            r_o_count  <= COUNT_W'(r_live);
            r_o_last   <= 1'b1;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {OUT_PAD_W'(0), r_o_count, r_o_handle, r_o_flow, r_o_status};
    assign o_m_tlast  = r_o_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_m_tready) |-> !(i_cmd.out_load || w_push_pend))
        else $error("output register overwritten while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_commit |-> (w_cand != '0) && !r_valid[w_cand_addr])
        else $error("add into a live slot or with flow id zero");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_commit |=> r_live == LIVE_W'($past(r_live) + LIVE_W'(1)))
        else $error("live count not bumped on add");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= LIVE_W'(SLOTS))
        else $error("live count above slot count");

endmodule

`default_nettype wire

>>> sv/connection_slot_table_core.sv
// connection slot table: open-addressed table of 64 connection slots keyed by flow id
// top level; depends on cst_pkg, cst_ctrl, cst_dp (and cst_ram below it)
//
// usage:
//  - input stream (i_s_*): one transaction per request; tuser carries the function
//    (add, lookup handle, touch, close, expire scan), tdata the flow id, handle,
//    kind, current time and deadline
//  - output stream (o_m_*): status, flow, handle and open count; tlast marks the
//    final result of a request; add/lookup/touch/close give one result, expire gives
//    one result per expired flow (at most 64) or a single "none expired" result
//  - one request at a time; o_s_tready is high only when the table is idle, so
//    a new request is accepted only once the previous result is in the output register
//  - lookup, touch, close: one ram read of the home slot, then the result and output registers
//  - add: one probe candidate per cycle against the slot valid bits
//  - expire: one slot read per cycle from the slot rams, except while the scan stalls
//  - functions 5 to 7 are accepted and dropped without a result
//  - results sit in an output register; when the receiver stalls, the table holds
//    (a scan pauses on a match while another match is pending) until the result is taken
//  - reset clears all valid bits and the open count: every slot is free
`default_nettype none

module connection_slot_table_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave side
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: flow_id[31:0], handle_in[47:32], conn_kind[55:48], now_time[87:56],
    //        deadline[119:88]
    input  wire logic [cst_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: func[2:0]
    input  wire logic [cst_pkg::FUNC_W-1:0]     i_s_tuser,
    // master side
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // tdata: status[1:0], flow_out[33:2], handle_out[49:34], open_count[56:50], zero above
    output logic      [cst_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                                o_m_tlast
);

    import cst_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    cst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cst_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

endmodule

`default_nettype wire
